// ===== sv/tlc_pkg.sv =====
// Package with the types, constants and codes shared by the two-level cache files.
package tlc_pkg;

    localparam int L1_MAX_SETS = 64;
    localparam int L1_MAX_WAYS = 4;
    localparam int L2_MAX_SETS = 256;
    localparam int L2_MAX_WAYS = 8;
    localparam int ADDR_BITS   = 32;
    localparam int LINE_TAG_W  = 30;
    localparam int ROW_WAYS    = 8;
    localparam int L1_SET_W    = 6;
    localparam int L2_SET_W    = 8;
    localparam int CLR_W       = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_SET_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WAY_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_SET_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAY_BITS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 3'd5;

    // One way of a set: tag, state bits and LRU rank.
    typedef struct packed {
        logic [LINE_TAG_W-1:0] tag;
        logic                  valid;
        logic                  dirty;
        logic [2:0]            rank;
    } t_way;

    // One set as stored in a memory row; the first level uses the low ways only.
    typedef t_way [ROW_WAYS-1:0] t_row;

    typedef enum logic [1:0] {
        UOP_HIT     = 2'd0,
        UOP_INSTALL = 2'd1,
        UOP_REMOVE  = 2'd2
    } t_uop;

    // Command to the shared set unit.
    typedef struct packed {
        t_uop                  op;
        logic [3:0]            ways;
        logic [LINE_TAG_W-1:0] tag;
        logic                  mark_dirty;
    } t_unit_cmd;

    // Status returned by the shared set unit.
    typedef struct packed {
        logic                  hit;
        logic                  old_valid;
        logic                  old_dirty;
        logic [LINE_TAG_W-1:0] old_tag;
    } t_unit_res;

endpackage

// ===== sv/tlc_req_if.sv =====
// Request channel interface: one access per transfer.
interface tlc_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] address;

    modport source (output valid, output op, output address, input ready);
    modport sink (input valid, input op, input address, output ready);
endinterface

// ===== sv/tlc_rsp_if.sv =====
// Result channel interface: one access outcome per transfer.
interface tlc_rsp_if;
    logic valid;
    logic ready;
    logic l1_hit;
    logic l2_hit;
    logic memory_access;
    logic dirty_victim;
    logic back_invalidate;

    modport source (output valid, output l1_hit, output l2_hit, output memory_access,
                    output dirty_victim, output back_invalidate, input ready);
    modport sink (input valid, input l1_hit, input l2_hit, input memory_access,
                  input dirty_victim, input back_invalidate, output ready);
endinterface

// ===== sv/tlc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/tlc_set_unit.sv =====
// Shared set unit: lookup, LRU touch, victim install and line removal on one set row.
module tlc_set_unit (
    input  tlc_pkg::t_row      i_row,
    input  tlc_pkg::t_unit_cmd i_cmd,
    output tlc_pkg::t_row      o_row,
    output tlc_pkg::t_unit_res o_res
);
    logic [tlc_pkg::ROW_WAYS-1:0] in_use;
    logic [tlc_pkg::ROW_WAYS-1:0] match;
    logic [2:0] hit_way;
    logic       hit;
    logic [2:0] free_way;
    logic       any_free;
    logic [2:0] lru_way;
    logic [2:0] sel;
    logic       act;
    logic       had;
    logic [2:0] prev;
    logic [2:0] top;

    // Way lookup and victim choice.
    always_comb begin
        hit_way  = '0;
        hit      = 1'b0;
        free_way = '0;
        any_free = 1'b0;
        lru_way  = '0;
        for (int i = 0; i < tlc_pkg::ROW_WAYS; i++) begin
            in_use[i] = 4'(i) < i_cmd.ways;
            match[i]  = in_use[i] && i_row[i].valid && (i_row[i].tag == i_cmd.tag);
        end
        for (int i = tlc_pkg::ROW_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_way = 3'(i);
            end
            if (in_use[i] && !i_row[i].valid) begin
                any_free = 1'b1;
                free_way = 3'(i);
            end
        end
        for (int i = 1; i < tlc_pkg::ROW_WAYS; i++) begin
            if (in_use[i] && (i_row[i].rank < i_row[lru_way].rank)) begin
                lru_way = 3'(i);
            end
        end
    end

    assign top  = 3'(i_cmd.ways - 4'd1);
    assign sel  = (i_cmd.op == tlc_pkg::UOP_INSTALL) ? (any_free ? free_way : lru_way)
                                                     : hit_way;
    assign act  = (i_cmd.op == tlc_pkg::UOP_INSTALL) || hit;
    assign had  = (i_cmd.op == tlc_pkg::UOP_INSTALL) ? i_row[sel].valid : 1'b1;
    assign prev = i_row[sel].rank;

    // Rank update of the other ways and the new state of the selected way.
    always_comb begin
        o_row = i_row;
        if (act) begin
            unique case (i_cmd.op)
                tlc_pkg::UOP_REMOVE: begin
                    for (int i = 0; i < tlc_pkg::ROW_WAYS; i++) begin
                        if (in_use[i] && i_row[i].valid && 3'(i) != sel &&
                            i_row[i].rank < prev && i_row[i].rank < top) begin
                            o_row[i].rank = i_row[i].rank + 3'd1;
                        end
                    end
                    o_row[sel].valid = 1'b0;
                    o_row[sel].dirty = 1'b0;
                    o_row[sel].rank  = '0;
                end
                tlc_pkg::UOP_HIT, tlc_pkg::UOP_INSTALL: begin
                    for (int i = 0; i < tlc_pkg::ROW_WAYS; i++) begin
                        if (in_use[i] && i_row[i].valid && 3'(i) != sel &&
                            (!had || i_row[i].rank > prev) && i_row[i].rank != 3'd0) begin
                            o_row[i].rank = i_row[i].rank - 3'd1;
                        end
                    end
                    o_row[sel].rank = top;
                    if (i_cmd.op == tlc_pkg::UOP_INSTALL) begin
                        o_row[sel].tag   = i_cmd.tag;
                        o_row[sel].valid = 1'b1;
                        o_row[sel].dirty = i_cmd.mark_dirty;
                    end else if (i_cmd.mark_dirty) begin
                        o_row[sel].dirty = 1'b1;
                    end
                end
                default: o_row = i_row;
            endcase
        end
    end

    assign o_res.hit       = hit;
    assign o_res.old_valid = i_row[sel].valid;
    assign o_res.old_dirty = i_row[sel].dirty;
    assign o_res.old_tag   = i_row[sel].tag;
endmodule

// ===== sv/two_level_inclusive_lru_cache.sv =====
// Top level of the two-level inclusive LRU tag cache with its access sequencer.
//
//  channel   direction  fields                                        transfer when
//  i_req     in         op, address                                   valid & ready
//  o_rsp     out        l1_hit, l2_hit, memory_access,                valid & ready
//                       dirty_victim, back_invalidate
//  i_cfg_*   in         i_cfg_idx, i_cfg_data                         i_cfg_we
//
// An access on a first-level hit runs the RD1 and L1 steps; a miss that fills both
// levels with a dirty victim and a back-invalidation also runs L2, INS1, RDV, DV, RD2,
// INS2, RDB and BI. Each unit pass works on one set row read from a tag memory.
// After reset a clearing pass zeroes both tag memories; no request is taken
// meanwhile. The result waits in the output register until taken, and the next
// request is taken once it has been transferred.
module two_level_inclusive_lru_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tlc_req_if.sink                           i_req,
    tlc_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tlc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    typedef enum logic [12:0] {
        S_CLR  = 13'b0000000000001,
        S_IDLE = 13'b0000000000010,
        S_RD1  = 13'b0000000000100,
        S_L1   = 13'b0000000001000,
        S_L2   = 13'b0000000010000,
        S_INS1 = 13'b0000000100000,
        S_RDV  = 13'b0000001000000,
        S_DV   = 13'b0000010000000,
        S_RD2  = 13'b0000100000000,
        S_INS2 = 13'b0001000000000,
        S_RDB  = 13'b0010000000000,
        S_BI   = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [tlc_pkg::CLR_W-1:0] r_clr;

    // Configuration registers.
    logic [3:0] r_cfg_bb;
    logic [2:0] r_cfg_s1;
    logic [1:0] r_cfg_w1;
    logic [3:0] r_cfg_s2;
    logic [1:0] r_cfg_w2;
    logic       r_cfg_wa;

    // Access context.
    logic                            r_is_wr;
    logic                            r_alloc;
    logic [2:0]                      r_s1;
    logic [3:0]                      r_s2;
    logic [3:0]                      r_w1;
    logic [3:0]                      r_w2;
    logic [tlc_pkg::L1_SET_W-1:0]    r_set1;
    logic [tlc_pkg::L2_SET_W-1:0]    r_set2;
    logic [tlc_pkg::LINE_TAG_W-1:0]  r_tag1;
    logic [tlc_pkg::LINE_TAG_W-1:0]  r_tag2;
    logic [tlc_pkg::L1_SET_W-1:0]    r_vset1;
    logic [tlc_pkg::L2_SET_W-1:0]    r_vset2;
    logic [tlc_pkg::LINE_TAG_W-1:0]  r_vtag;
    logic r_hit1, r_hit2, r_mem, r_dv, r_bi;

    // Effective configuration, saturated to the supported range.
    logic [3:0]  bb;
    logic [2:0]  s1;
    logic [3:0]  s2;
    logic [1:0]  w1b;
    logic [31:0] blk;
    logic [tlc_pkg::L1_SET_W-1:0] mask1;
    logic [tlc_pkg::L2_SET_W-1:0] mask2;
    logic [37:0] vb1;
    logic [37:0] vb2;

    assign bb    = (r_cfg_bb < 4'd2) ? 4'd2 : ((r_cfg_bb > 4'd8) ? 4'd8 : r_cfg_bb);
    assign s1    = (r_cfg_s1 > 3'd6) ? 3'd6 : r_cfg_s1;
    assign s2    = (r_cfg_s2 > 4'd8) ? 4'd8 : r_cfg_s2;
    assign w1b   = (r_cfg_w1 > 2'd2) ? 2'd2 : r_cfg_w1;
    assign blk   = i_req.address >> bb;
    assign mask1 = 6'((7'd1 << r_s1) - 7'd1);
    assign mask2 = 8'((9'd1 << r_s2) - 9'd1);

    // Memories and the shared set unit.
    tlc_pkg::t_row      l1_rdata, l2_rdata, u_row_in, u_row_out, wdata;
    tlc_pkg::t_unit_cmd u_cmd;
    tlc_pkg::t_unit_res u_res;
    logic l1_we, l2_we;
    logic [tlc_pkg::L1_SET_W-1:0] l1_waddr, l1_raddr;
    logic [tlc_pkg::L2_SET_W-1:0] l2_waddr, l2_raddr;

    tlc_ram #(.WIDTH($bits(tlc_pkg::t_row)), .DEPTH(tlc_pkg::L1_MAX_SETS)) u_l1_ram (
        .i_clk(i_clk), .i_we(l1_we), .i_waddr(l1_waddr), .i_wdata(wdata),
        .i_raddr(l1_raddr), .o_rdata(l1_rdata)
    );

    tlc_ram #(.WIDTH($bits(tlc_pkg::t_row)), .DEPTH(tlc_pkg::L2_MAX_SETS)) u_l2_ram (
        .i_clk(i_clk), .i_we(l2_we), .i_waddr(l2_waddr), .i_wdata(wdata),
        .i_raddr(l2_raddr), .o_rdata(l2_rdata)
    );

    tlc_set_unit u_set_unit (
        .i_row(u_row_in), .i_cmd(u_cmd), .o_row(u_row_out), .o_res(u_res)
    );

    // Victim block numbers mapped into the other level.
    assign vb1 = ({8'd0, u_res.old_tag} << r_s1) | 38'(r_set1);
    assign vb2 = ({8'd0, u_res.old_tag} << r_s2) | 38'(r_set2);

    // Unit command and memory port selection per step.
    always_comb begin
        u_row_in         = l1_rdata;
        u_cmd.op         = tlc_pkg::UOP_HIT;
        u_cmd.ways       = r_w1;
        u_cmd.tag        = r_tag1;
        u_cmd.mark_dirty = r_is_wr;
        priority case (1'b1)
            r_state == S_L2: begin
                u_row_in   = l2_rdata;
                u_cmd.ways = r_w2;
                u_cmd.tag  = r_tag2;
            end
            r_state == S_INS1: begin
                u_cmd.op = tlc_pkg::UOP_INSTALL;
            end
            r_state == S_DV: begin
                u_row_in         = l2_rdata;
                u_cmd.ways       = r_w2;
                u_cmd.tag        = r_vtag;
                u_cmd.mark_dirty = 1'b0;
            end
            r_state == S_INS2: begin
                u_row_in         = l2_rdata;
                u_cmd.op         = tlc_pkg::UOP_INSTALL;
                u_cmd.ways       = r_w2;
                u_cmd.tag        = r_tag2;
                u_cmd.mark_dirty = 1'b0;
            end
            r_state == S_BI: begin
                u_cmd.op         = tlc_pkg::UOP_REMOVE;
                u_cmd.tag        = r_vtag;
                u_cmd.mark_dirty = 1'b0;
            end
            default: u_cmd.op = tlc_pkg::UOP_HIT;
        endcase
    end

    assign wdata    = (r_state == S_CLR) ? '0 : u_row_out;
    assign l1_raddr = (r_state == S_RDB) ? r_vset1 : r_set1;
    assign l2_raddr = (r_state == S_RDV) ? r_vset2 : r_set2;
    assign l1_we    = (r_state == S_CLR) || (r_state == S_INS1) ||
                      (((r_state == S_L1) || (r_state == S_BI)) && u_res.hit);
    assign l2_we    = (r_state == S_CLR) || (r_state == S_L2) ||
                      (r_state == S_DV) || (r_state == S_INS2);
    assign l1_waddr = (r_state == S_CLR) ? r_clr[tlc_pkg::L1_SET_W-1:0] :
                      ((r_state == S_BI) ? r_vset1 : r_set1);
    assign l2_waddr = (r_state == S_CLR) ? r_clr[tlc_pkg::L2_SET_W-1:0] :
                      ((r_state == S_DV) ? r_vset2 : r_set2);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == 9'(tlc_pkg::L2_MAX_SETS - 1)) n_state = S_IDLE;
            S_IDLE: if (i_req.valid) n_state = S_RD1;
            S_RD1:  n_state = S_L1;
            S_L1:   n_state = u_res.hit ? S_OUT : S_L2;
            S_L2:   n_state = r_alloc ? S_INS1 : S_OUT;
            S_INS1: begin
                if (u_res.old_valid && u_res.old_dirty) begin
                    n_state = S_RDV;
                end else begin
                    n_state = r_mem ? S_RD2 : S_OUT;
                end
            end
            S_RDV:  n_state = S_DV;
            S_DV:   n_state = r_mem ? S_RD2 : S_OUT;
            S_RD2:  n_state = S_INS2;
            S_INS2: n_state = u_res.old_valid ? S_RDB : S_OUT;
            S_RDB:  n_state = S_BI;
            S_BI:   n_state = S_OUT;
            S_OUT:  if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cfg_bb <= 4'd4;
            r_cfg_s1 <= 3'd6;
            r_cfg_w1 <= 2'd2;
            r_cfg_s2 <= 4'd8;
            r_cfg_w2 <= 2'd3;
            r_cfg_wa <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 9'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tlc_pkg::CFG_BLOCK_BITS:  r_cfg_bb <= i_cfg_data;
                    tlc_pkg::CFG_L1_SET_BITS: r_cfg_s1 <= i_cfg_data[2:0];
                    tlc_pkg::CFG_L1_WAY_BITS: r_cfg_w1 <= i_cfg_data[1:0];
                    tlc_pkg::CFG_L2_SET_BITS: r_cfg_s2 <= i_cfg_data;
                    tlc_pkg::CFG_L2_WAY_BITS: r_cfg_w2 <= i_cfg_data[1:0];
                    tlc_pkg::CFG_WRITE_ALLOC: r_cfg_wa <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Access context and outcome flags.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    r_is_wr <= i_req.op;
                    r_alloc <= !i_req.op || r_cfg_wa;
                    r_s1    <= s1;
                    r_s2    <= s2;
                    r_w1    <= 4'd1 << w1b;
                    r_w2    <= 4'd1 << r_cfg_w2;
                    r_set1  <= blk[tlc_pkg::L1_SET_W-1:0] & 6'((7'd1 << s1) - 7'd1);
                    r_set2  <= blk[tlc_pkg::L2_SET_W-1:0] & 8'((9'd1 << s2) - 9'd1);
                    r_tag1  <= 30'(blk >> s1);
                    r_tag2  <= 30'(blk >> s2);
                    r_hit1  <= 1'b0;
                    r_hit2  <= 1'b0;
                    r_mem   <= 1'b0;
                    r_dv    <= 1'b0;
                    r_bi    <= 1'b0;
                end
            end
            S_L1: r_hit1 <= u_res.hit;
            S_L2: begin
                r_hit2 <= u_res.hit;
                r_mem  <= !u_res.hit;
            end
            S_INS1: begin
                if (u_res.old_valid && u_res.old_dirty) begin
                    r_dv    <= 1'b1;
                    r_vset2 <= vb1[tlc_pkg::L2_SET_W-1:0] & mask2;
                    r_vtag  <= 30'(vb1 >> r_s2);
                end
            end
            S_INS2: begin
                r_vset1 <= vb2[tlc_pkg::L1_SET_W-1:0] & mask1;
                r_vtag  <= 30'(vb2 >> r_s1);
            end
            S_BI: r_bi <= u_res.hit;
            default: ;
        endcase
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = (r_state == S_OUT);
    assign o_rsp.l1_hit          = r_hit1;
    assign o_rsp.l2_hit          = r_hit2;
    assign o_rsp.memory_access   = r_mem;
    assign o_rsp.dirty_victim    = r_dv;
    assign o_rsp.back_invalidate = r_bi;
endmodule

// ===== dv/two_level_inclusive_lru_cache_test.sv =====
// Self-checking testbench of the two-level inclusive LRU tag cache with a built-in predictor.
`timescale 1ns / 100ps

module two_level_inclusive_lru_cache_test;

    localparam int TAG_W = tlc_pkg::LINE_TAG_W;
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    // Indexes past the register list; the block must ignore writes to them.
    localparam logic [tlc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [tlc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES   = 20;

    typedef struct packed {
        logic l1_hit;
        logic l2_hit;
        logic memory_access;
        logic dirty_victim;
        logic back_invalidate;
    } t_outcome;

    typedef struct packed {
        logic        op;
        logic [31:0] address;
    } t_access;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tlc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tlc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    tlc_req_if req_ch ();
    tlc_rsp_if rsp_ch ();

    two_level_inclusive_lru_cache dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of both tag stores; level 0 is L1, level 1 is L2.
    logic [TAG_W-1:0] shadow_tag [2][tlc_pkg::L2_MAX_SETS*tlc_pkg::L2_MAX_WAYS];
    bit               shadow_valid [2][tlc_pkg::L2_MAX_SETS*tlc_pkg::L2_MAX_WAYS];
    bit               shadow_dirty [2][tlc_pkg::L2_MAX_SETS*tlc_pkg::L2_MAX_WAYS];
    int               shadow_rank [2][tlc_pkg::L2_MAX_SETS*tlc_pkg::L2_MAX_WAYS];

    // Shadow copy of the configuration registers.
    int cfg_block = 4, cfg_l1_sets = 6, cfg_l1_ways = 2;
    int cfg_l2_sets = 8, cfg_l2_ways = 3, cfg_wr_alloc = 1;

    t_access  pending_accesses [$];
    t_outcome expected_outcomes [$];
    int       mismatch_count = 0;
    bit       no_idle = 1'b0;

    function automatic int row_ways(int lvl);
        return (lvl == 0) ? tlc_pkg::L1_MAX_WAYS : tlc_pkg::L2_MAX_WAYS;
    endfunction

    function automatic int fit_bits(int bits, int hi, int max_count);
        if (bits > hi) bits = hi;
        while (bits > 0 && (1 << bits) > max_count) bits--;
        return bits;
    endfunction

    function automatic int find_way(int lvl, int set, int ways, logic [TAG_W-1:0] tag);
        int e;
        for (int i = 0; i < ways; i++) begin
            e = set * row_ways(lvl) + i;
            if (shadow_valid[lvl][e] && shadow_tag[lvl][e] == tag) return i;
        end
        return -1;
    endfunction

    // Make a way most recent; valid lines ranked above its old rank (all if it was empty) age by one.
    function automatic void touch_way(int lvl, int set, int ways, int way, bit had);
        int base, prev, e;
        base = set * row_ways(lvl);
        prev = shadow_rank[lvl][base + way];
        for (int i = 0; i < ways; i++) begin
            e = base + i;
            if (i == way || !shadow_valid[lvl][e]) continue;
            if ((!had || shadow_rank[lvl][e] > prev) && shadow_rank[lvl][e] > 0)
                shadow_rank[lvl][e]--;
        end
        shadow_rank[lvl][base + way] = ways - 1;
    endfunction

    function automatic int pick_victim(int lvl, int set, int ways);
        int base, best;
        base = set * row_ways(lvl);
        best = 0;
        for (int i = 0; i < ways; i++)
            if (!shadow_valid[lvl][base + i]) return i;
        for (int i = 1; i < ways; i++)
            if (shadow_rank[lvl][base + i] < shadow_rank[lvl][base + best]) best = i;
        return best;
    endfunction

    function automatic void install_line(int lvl, int set, int ways, logic [TAG_W-1:0] tag,
                                         bit dirty, output bit old_valid,
                                         output logic [TAG_W-1:0] old_tag,
                                         output bit old_dirty);
        int e;
        e = set * row_ways(lvl) + pick_victim(lvl, set, ways);
        old_valid = shadow_valid[lvl][e];
        old_tag = shadow_tag[lvl][e];
        old_dirty = shadow_dirty[lvl][e];
        shadow_tag[lvl][e] = tag;
        shadow_dirty[lvl][e] = dirty;
        touch_way(lvl, set, ways, e - set * row_ways(lvl), old_valid);
        shadow_valid[lvl][e] = 1'b1;
    endfunction

    // Drop a line; valid lines ranked below it move up by one.
    function automatic void remove_line(int lvl, int set, int ways, int way);
        int base, prev, e;
        base = set * row_ways(lvl);
        prev = shadow_rank[lvl][base + way];
        for (int i = 0; i < ways; i++) begin
            e = base + i;
            if (i == way || !shadow_valid[lvl][e]) continue;
            if (shadow_rank[lvl][e] < prev && shadow_rank[lvl][e] < ways - 1)
                shadow_rank[lvl][e]++;
        end
        shadow_valid[lvl][base + way] = 1'b0;
        shadow_dirty[lvl][base + way] = 1'b0;
        shadow_rank[lvl][base + way] = 0;
    endfunction

    // Work out the outcome of one access and update the shadow stores.
    function automatic t_outcome predict_access(t_access acc);
        t_outcome res;
        int bb, s1, s2, w1, w2, set1, set2, w, vs, vw;
        logic [63:0] blk, vb;
        logic [TAG_W-1:0] tag1, tag2, ot, vt;
        bit is_write, alloc, ov, od;
        res = '0;
        is_write = (acc.op == OP_WRITE);
        bb = (cfg_block < 2) ? 2 : ((cfg_block > 8) ? 8 : cfg_block);
        s1 = fit_bits(cfg_l1_sets, 6, tlc_pkg::L1_MAX_SETS);
        s2 = fit_bits(cfg_l2_sets, 8, tlc_pkg::L2_MAX_SETS);
        w1 = 1 << fit_bits(cfg_l1_ways, 2, tlc_pkg::L1_MAX_WAYS);
        w2 = 1 << fit_bits(cfg_l2_ways, 3, tlc_pkg::L2_MAX_WAYS);
        blk = {32'd0, acc.address} >> bb;
        set1 = int'(blk & ((64'd1 << s1) - 1));
        set2 = int'(blk & ((64'd1 << s2) - 1));
        tag1 = TAG_W'(blk >> s1);
        tag2 = TAG_W'(blk >> s2);
        alloc = !is_write || cfg_wr_alloc != 0;

        w = find_way(0, set1, w1, tag1);
        if (w >= 0) begin
            res.l1_hit = 1'b1;
            if (is_write) shadow_dirty[0][set1 * tlc_pkg::L1_MAX_WAYS + w] = 1'b1;
            touch_way(0, set1, w1, w, 1'b1);
            return res;
        end
        w = find_way(1, set2, w2, tag2);
        if (w >= 0) begin
            res.l2_hit = 1'b1;
            if (is_write) shadow_dirty[1][set2 * tlc_pkg::L2_MAX_WAYS + w] = 1'b1;
            touch_way(1, set2, w2, w, 1'b1);
        end else begin
            res.memory_access = 1'b1;
        end
        if (!alloc) return res;

        install_line(0, set1, w1, tag1, is_write, ov, ot, od);
        // A dirty L1 victim only refreshes its L2 copy.
        if (ov && od) begin
            vb = ({34'd0, ot} << s1) | 64'(set1);
            vs = int'(vb & ((64'd1 << s2) - 1));
            vt = TAG_W'(vb >> s2);
            res.dirty_victim = 1'b1;
            vw = find_way(1, vs, w2, vt);
            if (vw >= 0) touch_way(1, vs, w2, vw, 1'b1);
        end
        // An L2 eviction takes the matching L1 line with it.
        if (res.memory_access) begin
            install_line(1, set2, w2, tag2, 1'b0, ov, ot, od);
            if (ov) begin
                vb = ({34'd0, ot} << s2) | 64'(set2);
                vs = int'(vb & ((64'd1 << s1) - 1));
                vt = TAG_W'(vb >> s1);
                vw = find_way(0, vs, w1, vt);
                if (vw >= 0) begin
                    remove_line(0, vs, w1, vw);
                    res.back_invalidate = 1'b1;
                end
            end
        end
        return res;
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.op = OP_READ;
        req_ch.address = '0;
        rsp_ch.ready = 1'b0;
    end

    // Request driver: present the next pending access when the slot is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
                expected_outcomes.push_back(predict_access('{req_ch.op, req_ch.address}));
            end
            if (pending_accesses.size() > 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
                req_ch.valid <= 1'b1;
                req_ch.op <= pending_accesses[0].op;
                req_ch.address <= pending_accesses[0].address;
                void'(pending_accesses.pop_front());
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expected outcome.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transfer at %0t", $realtime);
                end else begin
                    if (expected_outcomes[0] !== {rsp_ch.l1_hit, rsp_ch.l2_hit,
                            rsp_ch.memory_access, rsp_ch.dirty_victim,
                            rsp_ch.back_invalidate}) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Outcome error at %0t: l1/l2/mem/dv/bi expected %b actual %b",
                                     $realtime, expected_outcomes[0],
                                     {rsp_ch.l1_hit, rsp_ch.l2_hit, rsp_ch.memory_access,
                                      rsp_ch.dirty_victim, rsp_ch.back_invalidate});
                    end
                    void'(expected_outcomes.pop_front());
                end
            end
            rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 26);
        end
    end

    task automatic write_reg(logic [tlc_pkg::CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= tlc_pkg::CFG_DATA_W'(value);
        case (idx)
            tlc_pkg::CFG_BLOCK_BITS:  cfg_block = value & 4'hF;
            tlc_pkg::CFG_L1_SET_BITS: cfg_l1_sets = value & 3'h7;
            tlc_pkg::CFG_L1_WAY_BITS: cfg_l1_ways = value & 2'h3;
            tlc_pkg::CFG_L2_SET_BITS: cfg_l2_sets = value & 4'hF;
            tlc_pkg::CFG_L2_WAY_BITS: cfg_l2_ways = value & 2'h3;
            tlc_pkg::CFG_WRITE_ALLOC: cfg_wr_alloc = value & 1'h1;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every access has been answered, then let the block settle.
    task automatic wait_drained();
        while (pending_accesses.size() > 0 || req_ch.valid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly addresses near a small pool so that lines hit, conflict and get evicted.
    function automatic logic [31:0] pick_address(logic [31:0] pool [6]);
        int shift;
        if ($urandom_range(0, 9) == 0) return $urandom;
        case ($urandom_range(0, 2))
            0: shift = cfg_block;
            1: shift = cfg_block + cfg_l1_sets;
            default: shift = cfg_block + cfg_l2_sets;
        endcase
        return pool[$urandom_range(0, 5)] + (32'($urandom_range(0, 15)) << (shift & 31))
               + $urandom_range(0, 3);
    endfunction

    int phase_cfg [8][6] = '{
        '{4, 6, 2, 8, 3, 1},
        '{2, 0, 0, 0, 0, 1},
        '{8, 6, 2, 8, 3, 0},
        '{0, 7, 3, 15, 3, 1},
        '{15, 2, 1, 3, 2, 0},
        '{5, 3, 1, 4, 2, 1},
        '{3, 1, 0, 2, 1, 1},
        '{9, 4, 2, 5, 1, 0}
    };

    // Stimulus: directed accesses under the reset setting, then random phases.
    initial begin
        logic [31:0] pool [6];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_accesses.push_back('{OP_READ, 32'h0000_0000});
        pending_accesses.push_back('{OP_READ, 32'h0000_0000});
        pending_accesses.push_back('{OP_WRITE, 32'h0000_0004});
        pending_accesses.push_back('{OP_READ, 32'hFFFF_FFFF});
        pending_accesses.push_back('{OP_WRITE, 32'hFFFF_FFF0});
        // Ten dirty lines in one set of both levels: dirty victims and back-invalidation.
        for (int k = 1; k <= 10; k++)
            pending_accesses.push_back('{OP_WRITE, 32'(k) << 12});
        pending_accesses.push_back('{OP_READ, 32'h0000_1000});
        pending_accesses.push_back('{OP_READ, 32'h0000_0000});
        pending_accesses.push_back('{OP_WRITE, 32'hAAAA_AAAA});
        pending_accesses.push_back('{OP_READ, 32'h5555_5555});
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                write_reg(CFG_SPARE_LO, 5);
                write_reg(CFG_SPARE_HI, 15);
            end
            write_reg(tlc_pkg::CFG_BLOCK_BITS, phase_cfg[p][0]);
            write_reg(tlc_pkg::CFG_L1_SET_BITS, phase_cfg[p][1]);
            write_reg(tlc_pkg::CFG_L1_WAY_BITS, phase_cfg[p][2]);
            write_reg(tlc_pkg::CFG_L2_SET_BITS, phase_cfg[p][3]);
            write_reg(tlc_pkg::CFG_L2_WAY_BITS, phase_cfg[p][4]);
            write_reg(tlc_pkg::CFG_WRITE_ALLOC, phase_cfg[p][5]);
            no_idle = (p == 2);
            foreach (pool[i]) pool[i] = $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_accesses.push_back('{1'($urandom_range(0, 1)), pick_address(pool)});
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
